### hw/rtl/lchc_pkg.sv
// ----------------------------------------------------------------------------
// lchc_pkg
// Shared constants, types and helpers for the LRU cache hit-cost block.
// ----------------------------------------------------------------------------
package lchc_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int KEY_W       = 64;
   localparam int SLOT_W      = 5;
   localparam int COST_W      = 32;
   localparam int CAP_W       = 6;

   localparam logic [COST_W-1:0] HIT_COST    = COST_W'(1);
   localparam logic [COST_W-1:0] MISS_COST   = COST_W'(5);
   localparam logic [7:0]        CASE_OFFSET = 8'd32;
   localparam logic [7:0]        CHAR_UPPER_A = 8'h41;
   localparam logic [7:0]        CHAR_UPPER_Z = 8'h5A;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             key_we;
      logic [IDX_W-1:0] key_waddr;
      logic [KEY_W-1:0] key_wdata;
      logic             rank_we;
      logic [IDX_W-1:0] rank_waddr;
      logic [IDX_W-1:0] rank_wdata;
   } store_req_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] rank;
   } store_rsp_type;

   // fold A-Z to lowercase in every byte
   function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      logic [7:0]       c;
      r = '0;
      for (int b = 0; b < KEY_W / 8; b++) begin
         c = k[8*b +: 8];
         if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            c = c + CASE_OFFSET;
         end
         r[8*b +: 8] = c;
      end
      return r;
   endfunction

endpackage

### hw/rtl/lchc_if.sv
// ----------------------------------------------------------------------------
// lchc_req_if / lchc_rsp_if
// Valid/ready channels for lookup requests and lookup results.
// ----------------------------------------------------------------------------
interface lchc_req_if;
   logic                        valid;
   logic                        ready;
   logic [lchc_pkg::KEY_W-1:0]  key;

   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface

interface lchc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [lchc_pkg::SLOT_W-1:0] slot;
   logic [lchc_pkg::COST_W-1:0] total_cost;

   modport source (output valid, output hit, output slot, output total_cost, input ready);
   modport sink   (input valid, input hit, input slot, input total_cost, output ready);
endinterface

### hw/rtl/lchc_store.sv
// ----------------------------------------------------------------------------
// lchc_store
// Entry key memory and recency rank memory, one read port and one write
// port each, registered read data.
// ----------------------------------------------------------------------------
module lchc_store (
   input  logic                    clock,
   input  lchc_pkg::store_req_type st_req,
   output lchc_pkg::store_rsp_type st_rsp
);

   logic [lchc_pkg::KEY_W-1:0] key_mem  [lchc_pkg::MAX_ENTRIES];
   logic [lchc_pkg::IDX_W-1:0] rank_mem [lchc_pkg::MAX_ENTRIES];
   logic [lchc_pkg::KEY_W-1:0] rd_key_ff;
   logic [lchc_pkg::IDX_W-1:0] rd_rank_ff;

   always_ff @(posedge clock) begin
      if (st_req.key_we) begin
         key_mem[st_req.key_waddr] <= st_req.key_wdata;
      end
      rd_key_ff <= key_mem[st_req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (st_req.rank_we) begin
         rank_mem[st_req.rank_waddr] <= st_req.rank_wdata;
      end
      rd_rank_ff <= rank_mem[st_req.rd_addr];
   end

   assign st_rsp.key  = rd_key_ff;
   assign st_rsp.rank = rd_rank_ff;

endmodule

### hw/rtl/lchc_ctrl.sv
// ----------------------------------------------------------------------------
// lchc_ctrl
// Lookup sequencer: scans filled entries, applies the previous recency
// update on the way, picks hit or victim and keeps the running cost.
// ----------------------------------------------------------------------------
module lchc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lchc_pkg::CNT_W-1:0]  cap,
   lchc_req_if.sink                    req,
   lchc_rsp_if.source                  rsp,
   output lchc_pkg::store_req_type     st_req,
   input  lchc_pkg::store_rsp_type     st_rsp
);

   localparam int IDX_W = lchc_pkg::IDX_W;
   localparam int CNT_W = lchc_pkg::CNT_W;

   lchc_pkg::state_type state_ff, state_in;

   logic [lchc_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]            iss_ff, iss_in;
   logic                        chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]            chk_idx_ff, chk_idx_in;
   logic                        hit_ff, hit_in;
   logic [IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]            hit_rank_ff, hit_rank_in;
   logic [IDX_W-1:0]            max_idx_ff, max_idx_in;
   logic [IDX_W-1:0]            max_rank_ff, max_rank_in;
   logic [CNT_W-1:0]            filled_ff, filled_in;
   logic                        pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]            pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]            pend_rank_ff, pend_rank_in;
   logic                        res_hit_ff, res_hit_in;
   logic [lchc_pkg::SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [lchc_pkg::COST_W-1:0] cost_ff, cost_in;
   logic                        rsp_vld_ff, rsp_vld_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [lchc_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [lchc_pkg::COST_W-1:0] rsp_cost_ff, rsp_cost_in;

   logic                        req_fire;
   logic                        scan_done;
   logic                        out_free;
   logic [IDX_W-1:0]            cor_rank;
   logic [lchc_pkg::COST_W:0]   cost_sum;

   assign req_fire  = req.valid && req.ready;
   assign scan_done = (iss_ff == filled_ff) && !chk_vld_ff;
   assign out_free  = !rsp_vld_ff || rsp.ready;
   assign cost_sum  = {1'b0, cost_ff} +
                      {1'b0, (res_hit_ff ? lchc_pkg::HIT_COST : lchc_pkg::MISS_COST)};

   // apply the outstanding recency update to the rank just read
   always_comb begin
      if (pend_vld_ff && chk_idx_ff == pend_idx_ff) begin
         cor_rank = '0;
      end else if (pend_vld_ff && {1'b0, st_rsp.rank} < pend_rank_ff) begin
         cor_rank = st_rsp.rank + IDX_W'(1);
      end else begin
         cor_rank = st_rsp.rank;
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      iss_in       = iss_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = iss_ff[IDX_W-1:0];
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      max_idx_in   = max_idx_ff;
      max_rank_in  = max_rank_ff;
      filled_in    = filled_ff;
      pend_vld_in  = pend_vld_ff;
      pend_idx_in  = pend_idx_ff;
      pend_rank_in = pend_rank_ff;
      res_hit_in   = res_hit_ff;
      res_slot_in  = res_slot_ff;
      cost_in      = cost_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_cost_in  = rsp_cost_ff;

      st_req.rd_addr    = iss_ff[IDX_W-1:0];
      st_req.key_we     = 1'b0;
      st_req.key_waddr  = '0;
      st_req.key_wdata  = key_ff;
      st_req.rank_we    = chk_vld_ff && pend_vld_ff;
      st_req.rank_waddr = chk_idx_ff;
      st_req.rank_wdata = cor_rank;

      unique case (state_ff)
         lchc_pkg::ST_IDLE: begin
            if (req_fire) begin
               key_in      = lchc_pkg::fold_key(req.key);
               iss_in      = '0;
               hit_in      = 1'b0;
               hit_idx_in  = '0;
               hit_rank_in = '0;
               max_idx_in  = '0;
               max_rank_in = '0;
               res_hit_in  = 1'b0;
               res_slot_in = '0;
               if (cap == '0) begin
                  state_in = lchc_pkg::ST_FIN;
               end else begin
                  state_in = lchc_pkg::ST_SCAN;
               end
            end
         end
         lchc_pkg::ST_SCAN: begin
            if (iss_ff != filled_ff) begin
               iss_in     = iss_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff) begin
               if (!hit_ff && st_rsp.key == key_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = chk_idx_ff;
                  hit_rank_in = cor_rank;
               end
               if (cor_rank > max_rank_ff) begin
                  max_idx_in  = chk_idx_ff;
                  max_rank_in = cor_rank;
               end
            end
            if (scan_done) begin
               state_in    = lchc_pkg::ST_FIN;
               pend_vld_in = 1'b1;
               if (hit_ff) begin
                  res_hit_in   = 1'b1;
                  res_slot_in  = lchc_pkg::SLOT_W'(hit_idx_ff);
                  pend_idx_in  = hit_idx_ff;
                  pend_rank_in = CNT_W'(hit_rank_ff);
               end else if (filled_ff < cap) begin
                  res_slot_in      = lchc_pkg::SLOT_W'(filled_ff[IDX_W-1:0]);
                  st_req.key_we    = 1'b1;
                  st_req.key_waddr = filled_ff[IDX_W-1:0];
                  filled_in        = filled_ff + CNT_W'(1);
                  pend_idx_in      = filled_ff[IDX_W-1:0];
                  pend_rank_in     = filled_ff + CNT_W'(1);
               end else begin
                  res_slot_in      = lchc_pkg::SLOT_W'(max_idx_ff);
                  st_req.key_we    = 1'b1;
                  st_req.key_waddr = max_idx_ff;
                  pend_idx_in      = max_idx_ff;
                  pend_rank_in     = CNT_W'(max_rank_ff);
               end
            end
         end
         lchc_pkg::ST_FIN: begin
            if (out_free) begin
               cost_in     = cost_sum[lchc_pkg::COST_W] ? '1 : cost_sum[lchc_pkg::COST_W-1:0];
               rsp_vld_in  = 1'b1;
               rsp_hit_in  = res_hit_ff;
               rsp_slot_in = res_slot_ff;
               rsp_cost_in = cost_in;
               state_in    = lchc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lchc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lchc_pkg::ST_IDLE;
         iss_ff      <= '0;
         chk_vld_ff  <= 1'b0;
         filled_ff   <= '0;
         pend_vld_ff <= 1'b0;
         cost_ff     <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         iss_ff      <= iss_in;
         chk_vld_ff  <= chk_vld_in;
         filled_ff   <= filled_in;
         pend_vld_ff <= pend_vld_in;
         cost_ff     <= cost_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      chk_idx_ff   <= chk_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      max_idx_ff   <= max_idx_in;
      max_rank_ff  <= max_rank_in;
      pend_idx_ff  <= pend_idx_in;
      pend_rank_ff <= pend_rank_in;
      res_hit_ff   <= res_hit_in;
      res_slot_ff  <= res_slot_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_cost_ff  <= rsp_cost_in;
   end

   assign req.ready      = (state_ff == lchc_pkg::ST_IDLE);
   assign rsp.valid      = rsp_vld_ff;
   assign rsp.hit        = rsp_hit_ff;
   assign rsp.slot       = rsp_slot_ff;
   assign rsp.total_cost = rsp_cost_ff;

   a_chk_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> state_ff == lchc_pkg::ST_SCAN)
      else $error("entry check outside scan");

   a_filled_max: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(lchc_pkg::MAX_ENTRIES))
      else $error("fill count beyond capacity");

   a_iss_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == lchc_pkg::ST_SCAN |-> iss_ff <= filled_ff)
      else $error("scan index past filled entries");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      filled_ff != $past(filled_ff) |-> $past(state_ff) == lchc_pkg::ST_SCAN
                                        && filled_ff == $past(filled_ff) + CNT_W'(1))
      else $error("fill count changed outside a miss fill");

endmodule

### hw/rtl/lru_cache_hit_cost.sv
// ----------------------------------------------------------------------------
// lru_cache_hit_cost
// Requests: one lookup at a time; a request beat is accepted only in the idle
//   state, so a new request waits until the previous lookup has issued its response.
// Scan: the key memory read port reads one entry per cycle during the lookup scan,
//   which visits every filled entry.
// Reset: synchronous; clears capacity, fill count and running cost.
// Fully associative LRU cache with saturating hit/miss cost accounting.
// ----------------------------------------------------------------------------
module lru_cache_hit_cost (
   input  logic                        clock,
   input  logic                        reset,
   lchc_req_if.sink                    req_port,
   lchc_rsp_if.source                  rsp_port,
   input  logic                        csr_we,
   input  logic [lchc_pkg::CAP_W-1:0]  csr_wdata
);

   logic [lchc_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [lchc_pkg::CNT_W-1:0] cap_eff;
   lchc_pkg::store_req_type    st_req;
   lchc_pkg::store_rsp_type    st_rsp;

   assign cap_in = csr_we ? csr_wdata : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // clamp capacity to the number of physical entries
   always_comb begin
      if (cap_ff > lchc_pkg::CAP_W'(lchc_pkg::MAX_ENTRIES)) begin
         cap_eff = lchc_pkg::CNT_W'(lchc_pkg::MAX_ENTRIES);
      end else begin
         cap_eff = lchc_pkg::CNT_W'(cap_ff);
      end
   end

   lchc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .cap    (cap_eff),
      .req    (req_port),
      .rsp    (rsp_port),
      .st_req (st_req),
      .st_rsp (st_rsp)
   );

   lchc_store u_store (
      .clock  (clock),
      .st_req (st_req),
      .st_rsp (st_rsp)
   );

endmodule

### bench/lchc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lchc_checker
// Watches the request, response and capacity ports of the LRU cache block,
// keeps its own copy of the cache contents, recency order and running cost,
// and compares every response beat with the oldest predicted lookup result.
// ----------------------------------------------------------------------------
module lchc_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [lchc_pkg::KEY_W-1:0]  req_key,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_hit,
   input  logic [lchc_pkg::SLOT_W-1:0] rsp_slot,
   input  logic [lchc_pkg::COST_W-1:0] rsp_total_cost,
   input  logic                        csr_we,
   input  logic [lchc_pkg::CAP_W-1:0]  csr_wdata,
   output int                          fail_count,
   output int                          pending_count
);

   typedef struct packed {
      logic                        hit;
      logic [lchc_pkg::SLOT_W-1:0] slot;
      logic [lchc_pkg::COST_W-1:0] total_cost;
   } lookup_result_type;

   lookup_result_type           lookup_q [$];
   logic [lchc_pkg::KEY_W-1:0]  line_key [lchc_pkg::MAX_ENTRIES];
   logic [lchc_pkg::IDX_W-1:0]  line_age [lchc_pkg::MAX_ENTRIES];
   int                          lines_used;
   logic [lchc_pkg::COST_W-1:0] cost_acc;
   logic [lchc_pkg::CAP_W-1:0]  capacity;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic logic [lchc_pkg::KEY_W-1:0] lower_key(
      input logic [lchc_pkg::KEY_W-1:0] k);
      logic [lchc_pkg::KEY_W-1:0] r;
      r = k;
      for (int b = 0; b < lchc_pkg::KEY_W / 8; b++) begin
         if (r[8*b +: 8] >= lchc_pkg::CHAR_UPPER_A &&
             r[8*b +: 8] <= lchc_pkg::CHAR_UPPER_Z) begin
            r[8*b + 5] = 1'b1;
         end
      end
      return r;
   endfunction

   task automatic charge(input logic [lchc_pkg::COST_W-1:0] amount);
      if (cost_acc > {lchc_pkg::COST_W{1'b1}} - amount) begin
         cost_acc = {lchc_pkg::COST_W{1'b1}};
      end else begin
         cost_acc = cost_acc + amount;
      end
   endtask

   // age every line more recent than old_rank, then make idx the newest
   task automatic promote(input int idx, input int old_rank);
      for (int i = 0; i < lines_used; i++) begin
         if (i != idx && int'(line_age[i]) < old_rank) begin
            line_age[i] = line_age[i] + 1'b1;
         end
      end
      line_age[idx] = '0;
   endtask

   task automatic predict_lookup(input logic [lchc_pkg::KEY_W-1:0] raw);
      logic [lchc_pkg::KEY_W-1:0] k;
      int                         limit;
      int                         found;
      int                         victim;
      lookup_result_type          res;
      k      = lower_key(raw);
      limit  = (int'(capacity) > lchc_pkg::MAX_ENTRIES) ? lchc_pkg::MAX_ENTRIES
                                                         : int'(capacity);
      found  = -1;
      victim = 0;
      res.hit  = 1'b0;
      res.slot = '0;
      if (limit == 0) begin
         charge(lchc_pkg::MISS_COST);
      end else begin
         for (int i = 0; i < lines_used; i++) begin
            if (found < 0 && line_key[i] == k) begin
               found = i;
            end
         end
         if (found >= 0) begin
            res.hit  = 1'b1;
            res.slot = found[lchc_pkg::SLOT_W-1:0];
            promote(found, int'(line_age[found]));
            charge(lchc_pkg::HIT_COST);
         end else if (lines_used < limit) begin
            res.slot             = lines_used[lchc_pkg::SLOT_W-1:0];
            line_key[lines_used] = k;
            lines_used           = lines_used + 1;
            promote(lines_used - 1, lines_used);
            charge(lchc_pkg::MISS_COST);
         end else begin
            for (int i = 1; i < lines_used; i++) begin
               if (line_age[i] > line_age[victim]) begin
                  victim = i;
               end
            end
            res.slot         = victim[lchc_pkg::SLOT_W-1:0];
            line_key[victim] = k;
            promote(victim, int'(line_age[victim]));
            charge(lchc_pkg::MISS_COST);
         end
      end
      res.total_cost = cost_acc;
      lookup_q = {lookup_q, res};
   endtask

   always @(posedge clock) begin : watch
      lookup_result_type want;
      if (reset) begin
         lookup_q.delete();
         lines_used    = 0;
         cost_acc      = '0;
         capacity      = '0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (lookup_q.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected response beat: hit %0d slot %0d cost %0d",
                           rsp_hit, rsp_slot, rsp_total_cost);
               end
               fail_count = fail_count + 1;
            end else begin
               want = lookup_q.pop_front();
               if (want.hit !== rsp_hit || want.slot !== rsp_slot ||
                   want.total_cost !== rsp_total_cost) begin
                  if (fail_count < 10) begin
                     $display({"lookup mismatch: hit exp %0d act %0d, ",
                               "slot exp %0d act %0d, cost exp %0d act %0d"},
                              want.hit, rsp_hit, want.slot, rsp_slot,
                              want.total_cost, rsp_total_cost);
                  end
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_lookup(req_key);
         end
         if (csr_we) begin
            capacity = csr_wdata;
         end
         pending_count <= lookup_q.size();
      end
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the LRU cache block with directed keys around the case-folding
// boundaries and capacity corners, then phases of random keys drawn from
// small word pools under varying capacities, with random gaps on the request
// side and random stalls on the response side. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int POOL_DEPTH      = 48;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_we;
   logic [lchc_pkg::CAP_W-1:0] csr_wdata;
   logic                       calm;
   int                         rsp_hold = 0;
   int                         fail_count;
   int                         pending_count;

   lchc_req_if req_if ();
   lchc_rsp_if rsp_if ();

   lru_cache_hit_cost u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_if),
      .rsp_port  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   lchc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_key        (req_if.key),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_hit        (rsp_if.hit),
      .rsp_slot       (rsp_if.slot),
      .rsp_total_cost (rsp_if.total_cost),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   always #5 clock = ~clock;

   initial begin
      #8_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [lchc_pkg::KEY_W-1:0] text_key(input string s);
      logic [lchc_pkg::KEY_W-1:0] r;
      r = '0;
      for (int i = 0; i < s.len() && i < lchc_pkg::KEY_W / 8; i++) begin
         r[8*i +: 8] = s[i];
      end
      return r;
   endfunction

   // response side: alternate ready stretches and stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold     <= 0;
      end else if (calm) begin
         rsp_if.ready <= 1'b1;
         rsp_hold     <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_if.ready) begin
         rsp_if.ready <= 1'b0;
         rsp_hold     <= idle_len();
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_hold     <= $urandom_range(0, 20);
      end
   end

   // hold the beat until accepted; valid stays high into a back-to-back beat
   task automatic send_key(input logic [lchc_pkg::KEY_W-1:0] k);
      int gap;
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         req_if.key   <= {$urandom, $urandom};
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.key   <= k;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input int value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= lchc_pkg::CAP_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      logic [lchc_pkg::KEY_W-1:0] word_pool [POOL_DEPTH];
      logic [lchc_pkg::KEY_W-1:0] k;
      logic [7:0]                 c;
      int                         cap;
      int                         pool_size;
      int                         len;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      calm         = 1'b0;
      req_if.valid = 1'b0;
      req_if.key   = '0;
      rsp_if.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero capacity straight out of reset
      send_key('0);
      send_key({lchc_pkg::KEY_W{1'b1}});

      write_capacity(1);
      send_key(text_key("ABC"));
      send_key(text_key("abc"));
      send_key(text_key("xyz"));
      send_key(text_key("XyZ"));

      // bytes just outside and at the edges of the uppercase range
      write_capacity(3);
      send_key(64'h0000_0000_7B60_5B40);
      send_key(text_key("AZaz"));
      send_key(text_key("azAZ"));
      send_key(64'h0000_0000_7B60_5B40);
      send_key({lchc_pkg::KEY_W{1'b1}});
      send_key(text_key("xyz"));

      // capacity below the fill count keeps every line
      write_capacity(2);
      send_key(text_key("AZAZ"));
      send_key(text_key("qq"));
      send_key(text_key("QQ"));

      write_capacity(0);
      send_key(text_key("AZAZ"));

      // above the entry count acts as full size
      write_capacity(63);
      send_key(text_key("azaz"));
      send_key(text_key("ABCDEFGH"));
      send_key(text_key("abcdefgh"));
      send_key(64'h4100_0000_0000_0000);
      send_key(64'h6100_0000_0000_0000);

      for (int p = 0; p < PHASES; p++) begin
         unique case (p)
            0:       cap = 32;
            1:       cap = 1;
            2:       cap = 0;
            3:       cap = 63;
            4:       cap = 33;
            5:       cap = 2;
            default: cap = $urandom_range(0, 63);
         endcase
         write_capacity(cap);
         calm <= (p % 4 == 3);
         pool_size = $urandom_range(1, POOL_DEPTH);
         for (int w = 0; w < pool_size; w++) begin
            word_pool[w] = '0;
            len = $urandom_range(1, 8);
            for (int b = 0; b < len; b++) begin
               if ($urandom_range(0, 4) != 0) begin
                  word_pool[w][8*b +: 8] = 8'(8'h61 + $urandom_range(0, 25));
               end else begin
                  word_pool[w][8*b +: 8] = 8'($urandom_range(8'h20, 8'h7E));
               end
            end
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               k = {$urandom, $urandom};
            end else begin
               k = word_pool[$urandom_range(0, pool_size - 1)];
               for (int b = 0; b < lchc_pkg::KEY_W / 8; b++) begin
                  c = k[8*b +: 8];
                  if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) begin
                     k[8*b + 5] = 1'b0;
                  end
               end
            end
            send_key(k);
            if ($urandom_range(0, 59) == 0) begin
               wait_drained();
            end
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
